// ----- hw/rtl/set_membership_filter_macros.svh -----
// Assertion helpers for the membership filter.
// All checks sample on clk_i and are off while rst_ni is low.
`ifndef SET_MEMBERSHIP_FILTER_MACROS_SVH
`define SET_MEMBERSHIP_FILTER_MACROS_SVH

// Same-cycle implication.
`define SMF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SMF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/smf_pkg.sv -----
package smf_pkg;

  // Table geometry
  localparam int unsigned TableDepth = 64;
  localparam int unsigned AddrW      = $clog2(TableDepth);
  localparam int unsigned CountW     = $clog2(TableDepth + 1);
  localparam int unsigned ValueW     = 32;

  // Item operation codes; code 3 is unused and passes through
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_PROBE  = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  // Result flags, packed as on the output tuser
  typedef struct packed {
    logic overflow;
    logic kept;
  } res_flags_t;

endpackage

// ----- hw/rtl/smf_ram.sv -----
module smf_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/set_membership_filter.sv -----
// Membership filter over a table of distinct 32-bit values.
// s_axis carries one item per transfer: tuser[1:0] is the operation
// (insert, probe, clear), tdata[31:0] the value. m_axis returns exactly one
// result per item: tdata[31:0] echoes the value (zero for a clear),
// tuser[0] is the kept flag of a probe, tuser[1] the overflow flag of an
// insert into a full table. cfg_valid_i/cfg_data_i write keep_mode
// (0 keeps absent probes, 1 keeps present ones); cfg_ready_o is always high.
// Values sit in a single-port-read RAM filled in order, so entries below the
// fill count are the valid ones. An insert or probe scans them one read per
// cycle, reading entries up to and including a match, else up to the fill
// count; a clear or unused code skips the scan. The next item is accepted
// only once the result of the last one is loaded into the output register.
// An output register holds a result while the
// receiver stalls; the next item is still accepted and scanned, and waits
// in its final state until the output register frees up.
// Reset empties the table (fill count to zero) at once and sets keep_mode
// to difference; no clearing pass is needed.
`include "set_membership_filter_macros.svh"

module set_membership_filter (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,     // keep_mode
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  input  logic [7:0]  s_axis_tuser,   // [1:0] op, rest zero
  // results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] result_value
  output logic [7:0]  m_axis_tuser    // [0] kept, [1] overflow, rest zero
);

  localparam logic [smf_pkg::CountW-1:0] FullCount =
    smf_pkg::CountW'(smf_pkg::TableDepth);

  smf_pkg::state_e state_q, state_d;
  logic [1:0]                   op_q;
  logic [smf_pkg::ValueW-1:0]   val_q;
  logic [smf_pkg::CountW-1:0]   count_q, count_d;
  logic [smf_pkg::CountW-1:0]   idx_q, idx_d;
  logic                         cmp_vld_q, cmp_vld_d;
  logic                         found_q, found_d;
  logic                         mode_q;

  logic                         out_vld_q, out_vld_d;
  logic [smf_pkg::ValueW-1:0]   out_data_q;
  smf_pkg::res_flags_t          out_flags_q, out_flags_d;
  logic [smf_pkg::ValueW-1:0]   out_data_d;
  logic                         out_load;

  logic                         in_xfer;
  logic                         hit;
  logic                         ram_re, ram_we;
  logic [smf_pkg::ValueW-1:0]   ram_rdata;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == smf_pkg::ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // Value table
  smf_ram #(
    .Width (smf_pkg::ValueW),
    .Depth (smf_pkg::TableDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[smf_pkg::AddrW-1:0]),
    .wdata_i (val_q),
    .re_i    (ram_re),
    .raddr_i (idx_q[smf_pkg::AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Compare the entry read in the previous cycle
  assign hit = cmp_vld_q && (ram_rdata == val_q);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    cmp_vld_d   = 1'b0;
    found_d     = found_q;
    count_d     = count_q;
    ram_re      = 1'b0;
    ram_we      = 1'b0;
    out_load    = 1'b0;
    out_data_d  = val_q;
    out_flags_d = '0;

    unique case (state_q)
      smf_pkg::ST_IDLE: begin
        idx_d   = '0;
        found_d = 1'b0;
        if (in_xfer) begin
          if ((s_axis_tuser[1:0] == smf_pkg::OP_INSERT) ||
              (s_axis_tuser[1:0] == smf_pkg::OP_PROBE)) begin
            state_d = smf_pkg::ST_SCAN;
          end else begin
            state_d = smf_pkg::ST_FINISH;
          end
        end
      end
      smf_pkg::ST_SCAN: begin
        priority if (hit) begin
          found_d = 1'b1;
          state_d = smf_pkg::ST_FINISH;
        end else if (idx_q != count_q) begin
          ram_re    = 1'b1;
          cmp_vld_d = 1'b1;
          idx_d     = idx_q + 1'b1;
        end else begin
          state_d = smf_pkg::ST_FINISH;
        end
      end
      smf_pkg::ST_FINISH: begin
        unique case (op_q)
          smf_pkg::OP_INSERT: begin
            out_flags_d.overflow = !found_q && (count_q == FullCount);
          end
          smf_pkg::OP_PROBE: begin
            out_flags_d.kept = mode_q ? found_q : !found_q;
          end
          smf_pkg::OP_CLEAR: begin
            out_data_d = '0;
          end
          default: begin
          end
        endcase
        if (!out_vld_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = smf_pkg::ST_IDLE;
          if ((op_q == smf_pkg::OP_INSERT) && !found_q && (count_q != FullCount)) begin
            ram_we  = 1'b1;
            count_d = count_q + 1'b1;
          end else if (op_q == smf_pkg::OP_CLEAR) begin
            count_d = '0;
          end
        end
      end
      default: begin
        state_d = smf_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= smf_pkg::ST_IDLE;
      count_q   <= '0;
      idx_q     <= '0;
      cmp_vld_q <= 1'b0;
      found_q   <= 1'b0;
      mode_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      idx_q     <= idx_d;
      cmp_vld_q <= cmp_vld_d;
      found_q   <= found_d;
      out_vld_q <= out_vld_d;
      if (cfg_valid_i && cfg_ready_o) begin
        mode_q <= cfg_data_i;
      end
    end
  end

  // Item capture and output payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q  <= s_axis_tuser[1:0];
      val_q <= s_axis_tdata;
    end
    if (out_load) begin
      out_data_q  <= out_data_d;
      out_flags_q <= out_flags_d;
    end
  end

  // Output register occupancy
  always_comb begin
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = {6'b0, out_flags_q};

  // Checks
  `SMF_ASSERT_NOW(a_count_bound, 1'b1, count_q <= FullCount, "fill count above table depth")
  `SMF_ASSERT_NOW(a_write_room, ram_we, count_q < FullCount, "table write with table full")
  `SMF_ASSERT_NEXT(a_accept_busy, in_xfer, state_q != smf_pkg::ST_IDLE, "item accepted, no work")
  `SMF_ASSERT_NOW(a_scan_range, state_q == smf_pkg::ST_SCAN, idx_q <= count_q,
                  "scan index past fill count")

endmodule
